### sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled during reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Clocked property check that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

### sv/mtep_pkg.sv
// Types, constants and helpers of the MIDI track event parser.
package mtep_pkg;

  localparam int TRACK_COUNT = 16;
  localparam int TRK_AW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

  typedef enum logic [9:0] {
    PH_DELTA  = 10'b00_0000_0001,
    PH_STATUS = 10'b00_0000_0010,
    PH_DATA1  = 10'b00_0000_0100,
    PH_DATA2  = 10'b00_0000_1000,
    PH_MTYPE  = 10'b00_0001_0000,
    PH_MLEN   = 10'b00_0010_0000,
    PH_MDATA  = 10'b00_0100_0000,
    PH_SXLEN  = 10'b00_1000_0000,
    PH_SXDATA = 10'b01_0000_0000,
    PH_ENDED  = 10'b10_0000_0000
  } phase_t;

  localparam logic [3:0] EV_DELTA     = 4'd0;
  localparam logic [3:0] EV_OFF       = 4'd1;
  localparam logic [3:0] EV_ON        = 4'd2;
  localparam logic [3:0] EV_VOL       = 4'd3;
  localparam logic [3:0] EV_PAN       = 4'd4;
  localparam logic [3:0] EV_EXPR      = 4'd5;
  localparam logic [3:0] EV_SND_OFF   = 4'd6;
  localparam logic [3:0] EV_RST_CTL   = 4'd7;
  localparam logic [3:0] EV_NOTES_OFF = 4'd8;
  localparam logic [3:0] EV_PROG      = 4'd9;
  localparam logic [3:0] EV_PRESS     = 4'd10;
  localparam logic [3:0] EV_BEND      = 4'd11;
  localparam logic [3:0] EV_TEMPO     = 4'd12;
  localparam logic [3:0] EV_END       = 4'd13;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_PRESS    = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [6:0] CC_VOLUME    = 7'd7;
  localparam logic [6:0] CC_PAN       = 7'd10;
  localparam logic [6:0] CC_EXPR      = 7'd11;
  localparam logic [6:0] CC_SND_OFF   = 7'd120;
  localparam logic [6:0] CC_RST_CTL   = 7'd121;
  localparam logic [6:0] CC_NOTES_OFF = 7'd123;

  localparam logic [7:0] META_STATUS    = 8'hFF;
  localparam logic [7:0] SYS_FIRST      = 8'hF0;
  localparam logic [7:0] META_END       = 8'h2F;
  localparam logic [7:0] META_SET_TEMPO = 8'h51;
  localparam logic [6:0] VOL_RESET      = 7'd127;

  typedef struct packed {
    logic [3:0] track;
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_track;
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [6:0]  key_or_number;
    logic [6:0]  velocity;
    logic [31:0] value;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  running_status;
    logic [6:0]  first_data;
    logic [27:0] length_acc;
    logic [7:0]  meta_type;
    logic [27:0] bytes_remaining;
    logic [31:0] tempo_acc;
  } trk_state_t;

  typedef struct packed {
    logic       en;
    logic [3:0] ch;
    logic [6:0] vol;
  } vol_wr_t;

  localparam trk_state_t TRK_CLEAR = '{
    phase: PH_DELTA, running_status: 8'd0, first_data: 7'd0, length_acc: 28'd0,
    meta_type: 8'd0, bytes_remaining: 28'd0, tempo_acc: 32'd0};

  // vol*d/127 for vol, d below 128: reciprocal with correction, exact here.
  function automatic logic [6:0] scale127(input logic [6:0] vol, input logic [6:0] d);
    logic [13:0] prod;
    logic [14:0] sum;
    prod = vol * d;
    sum  = {1'b0, prod} + 15'd1 + {8'd0, prod[13:7]};
    return sum[13:7];
  endfunction

endpackage

### sv/mtep_decode.sv
// Next-state and event decode for one byte of one track.
module mtep_decode import mtep_pkg::*; (
  input  trk_state_t cur,
  input  logic [3:0] track,
  input  logic [7:0] data_byte,
  input  logic [6:0] ch_vol,
  output trk_state_t nxt,
  output logic       emit,
  output out_item_t  ev,
  output vol_wr_t    vol_wr
);

  logic        more;
  logic [6:0]  d;
  logic [27:0] acc;
  logic [3:0]  ch;
  logic [27:0] rem_dec;
  logic [31:0] tempo_sh;

  assign more     = data_byte[7];
  assign d        = data_byte[6:0];
  assign acc      = {cur.length_acc[20:0], d};
  assign ch       = cur.running_status[3:0];
  assign rem_dec  = cur.bytes_remaining - 28'd1;
  assign tempo_sh = {cur.tempo_acc[23:0], data_byte};

  always_comb begin
    nxt    = cur;
    emit   = 1'b0;
    ev     = '0;
    vol_wr = '0;
    ev.out_track = track;
    case (cur.phase)
      PH_DELTA: begin
        if (more) begin
          nxt.length_acc = acc;
        end else begin
          nxt.length_acc = '0;
          nxt.phase      = PH_STATUS;
          emit           = 1'b1;
          ev.event_kind  = EV_DELTA;
          ev.value       = {4'd0, acc};
        end
      end
      PH_STATUS, PH_DATA1: begin
        if (cur.phase == PH_STATUS && more) begin
          nxt.length_acc = '0;
          if (data_byte == META_STATUS) begin
            nxt.running_status = '0;
            nxt.phase          = PH_MTYPE;
          end else if (data_byte >= SYS_FIRST) begin
            nxt.running_status = '0;
            nxt.phase          = PH_SXLEN;
          end else begin
            nxt.running_status = data_byte;
            nxt.phase          = PH_DATA1;
          end
        end else if (cur.running_status[7]) begin
          // first data byte, possibly under running status
          nxt.first_data = d;
          ev.channel     = ch;
          case (cur.running_status[7:4])
            ST_PROG: begin
              nxt.phase        = PH_DELTA;
              emit             = 1'b1;
              ev.event_kind    = EV_PROG;
              ev.key_or_number = d;
            end
            ST_PRESS: begin
              nxt.phase     = PH_DELTA;
              emit          = 1'b1;
              ev.event_kind = EV_PRESS;
              ev.velocity   = d;
              ev.value      = {25'd0, scale127(ch_vol, d)};
            end
            default: nxt.phase = PH_DATA2;
          endcase
        end
      end
      PH_DATA2: begin
        nxt.phase   = PH_DELTA;
        ev.channel  = ch;
        ev.velocity = d;
        case (cur.running_status[7:4])
          ST_NOTE_OFF: begin
            emit             = 1'b1;
            ev.event_kind    = EV_OFF;
            ev.key_or_number = cur.first_data;
          end
          ST_NOTE_ON: begin
            emit             = 1'b1;
            ev.event_kind    = (d == 7'd0) ? EV_OFF : EV_ON;
            ev.key_or_number = cur.first_data;
          end
          ST_CTRL: begin
            case (cur.first_data)
              CC_VOLUME: begin
                emit          = 1'b1;
                ev.event_kind = EV_VOL;
                ev.value      = {25'd0, d};
                vol_wr        = '{en: 1'b1, ch: ch, vol: d};
              end
              CC_PAN: begin
                emit          = 1'b1;
                ev.event_kind = EV_PAN;
              end
              CC_EXPR: begin
                emit          = 1'b1;
                ev.event_kind = EV_EXPR;
                ev.value      = {25'd0, scale127(ch_vol, d)};
              end
              CC_SND_OFF: begin
                emit          = 1'b1;
                ev.event_kind = EV_SND_OFF;
              end
              CC_RST_CTL: begin
                emit          = 1'b1;
                ev.event_kind = EV_RST_CTL;
              end
              CC_NOTES_OFF: begin
                emit          = 1'b1;
                ev.event_kind = EV_NOTES_OFF;
              end
              default: emit = 1'b0;
            endcase
          end
          ST_BEND: begin
            emit          = 1'b1;
            ev.event_kind = EV_BEND;
            ev.velocity   = '0;
            ev.value      = {18'd0, d, cur.first_data};
          end
          default: emit = 1'b0;
        endcase
      end
      PH_MTYPE: begin
        nxt.meta_type  = data_byte;
        nxt.length_acc = '0;
        nxt.phase      = PH_MLEN;
      end
      PH_MLEN: begin
        if (more) begin
          nxt.length_acc = acc;
        end else begin
          nxt.length_acc      = '0;
          nxt.tempo_acc       = '0;
          nxt.bytes_remaining = acc;
          if (cur.meta_type == META_END) begin
            nxt.phase     = PH_ENDED;
            emit          = 1'b1;
            ev.event_kind = EV_END;
          end else if (acc == 28'd0) begin
            nxt.phase     = PH_DELTA;
            emit          = (cur.meta_type == META_SET_TEMPO);
            ev.event_kind = EV_TEMPO;
          end else begin
            nxt.phase = PH_MDATA;
          end
        end
      end
      PH_MDATA: begin
        nxt.tempo_acc       = tempo_sh;
        nxt.bytes_remaining = rem_dec;
        if (rem_dec == 28'd0) begin
          nxt.phase     = PH_DELTA;
          emit          = (cur.meta_type == META_SET_TEMPO);
          ev.event_kind = EV_TEMPO;
          ev.value      = tempo_sh;
        end
      end
      PH_SXLEN: begin
        if (more) begin
          nxt.length_acc = acc;
        end else begin
          nxt.length_acc      = '0;
          nxt.bytes_remaining = acc;
          nxt.phase           = (acc == 28'd0) ? PH_DELTA : PH_SXDATA;
        end
      end
      PH_SXDATA: begin
        nxt.bytes_remaining = rem_dec;
        if (rem_dec == 28'd0) begin
          nxt.phase = PH_DELTA;
        end
      end
      default: emit = 1'b0;
    endcase
  end

endmodule

### sv/midi_track_event_parser_top.sv
// Top level of the MIDI track event parser: state memory, pipeline and output register.
//
// Usage
//   Input channel in_valid/in_ready/in_item carries one track-chunk body byte,
//   tagged with its track number and a track_start flag that restarts that
//   track's parser before the byte is taken. Tracks may be interleaved freely.
//   Output channel out_valid/out_ready/out_item carries decoded events; a byte
//   gives at most one event, many give none.
//   Flow: the accepting edge reads the per-track state memory into the decode
//   stage; the edge on which that stage advances writes the state back and
//   loads the output register.
//   Throughput: one byte per cycle, any mix of tracks, unless the output stalls.
//   The state memory is read on accept and written as the decode stage advances;
//   a read of the track written at the same edge is served from a forwarding register.
//   Stalls: while out_ready is low with an event held, the decode stage holds
//   its byte and in_ready falls once that stage is full; nothing is dropped.
//   Reset: rst (synchronous, active high) clears per-entry valid bits, so every
//   track reads as freshly started, and sets all 16 channel volumes to 127.
//   Accepting bytes resumes on the first cycle after reset.
module midi_track_event_parser_top import mtep_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

`include "assert_macros.svh"

  // per-track parser state, one entry per track
  trk_state_t             state_mem [TRACK_COUNT];
  logic [TRACK_COUNT-1:0] entry_valid;
  trk_state_t             rd_data;
  logic                   rd_valid;

  // channel volumes, shared by all tracks
  logic [6:0] chan_vol [16];

  // decode stage
  logic              s1_valid;
  logic [3:0]        s1_track;
  logic [7:0]        s1_byte;
  logic              s1_start;
  logic              fwd_hit;
  trk_state_t        fwd_data;

  logic              advance;
  logic              accept;
  logic              in_range;
  logic              s1_write;
  logic [TRK_AW-1:0] in_addr;
  logic [TRK_AW-1:0] s1_addr;
  trk_state_t        cur;
  trk_state_t        nxt;
  logic              emit;
  out_item_t         ev;
  vol_wr_t           vol_wr;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, in_item.track} < 5'(TRACK_COUNT));
  assign in_addr  = TRK_AW'(in_item.track);
  assign s1_addr  = TRK_AW'(s1_track);
  assign s1_write = s1_valid && advance;

  always_comb begin
    if (s1_start) begin
      cur = TRK_CLEAR;
    end else if (fwd_hit) begin
      cur = fwd_data;
    end else if (rd_valid) begin
      cur = rd_data;
    end else begin
      cur = TRK_CLEAR;
    end
  end

  mtep_decode u_decode (
    .cur       (cur),
    .track     (s1_track),
    .data_byte (s1_byte),
    .ch_vol    (chan_vol[cur.running_status[3:0]]),
    .nxt       (nxt),
    .emit      (emit),
    .ev        (ev),
    .vol_wr    (vol_wr)
  );

  // state memory: one read at accept, one write-back from the decode stage
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= state_mem[in_addr];
    end
    if (s1_write) begin
      state_mem[s1_addr] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
      fwd_hit     <= 1'b0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        chan_vol[i] <= VOL_RESET;
      end
    end else begin
      if (accept) begin
        rd_valid <= entry_valid[in_addr];
        // memory returns old data when the same entry is written this edge
        fwd_hit  <= s1_write && (s1_addr == in_addr);
      end else if (advance) begin
        fwd_hit  <= 1'b0;
      end
      if (s1_write) begin
        entry_valid[s1_addr] <= 1'b1;
        if (vol_wr.en) begin
          chan_vol[vol_wr.ch] <= vol_wr.vol;
        end
      end
      if (accept) begin
        s1_valid <= in_range;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid && emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_track <= in_item.track;
      s1_byte  <= in_item.data_byte;
      s1_start <= in_item.track_start;
    end
    if (s1_write) begin
      fwd_data <= nxt;
    end
    if (advance && s1_valid && emit) begin
      out_item <= ev;
    end
  end

  `ASSERT_CLK(a_empty_stage_ready, clk, rst, !s1_valid |-> in_ready, "empty decode stage not ready")
  `ASSERT_CLK(a_fwd_needs_item, clk, rst, fwd_hit |-> s1_valid, "forward hit without an item")
  `ASSERT_CLK(a_stall_holds, clk, rst, (s1_valid && !advance) |=> (s1_valid && $stable(s1_track)), "decode stage lost item on stall")
  `ASSERT_CLK(a_kind_range, clk, rst, out_valid |-> (out_item.event_kind <= EV_END), "event kind out of range")

endmodule

### test/midi_track_event_parser_top_test.sv
// Self-checking testbench of the MIDI track event parser top level.
`timescale 1ns / 100ps

module midi_track_event_parser_top_test;
  import mtep_pkg::*;

  // Parse phases of the predictor, one per track.
  typedef enum int {
    P_DELTA, P_STATUS, P_DATA1, P_DATA2, P_MTYPE, P_MLEN, P_MDATA,
    P_SXLEN, P_SXDATA, P_ENDED
  } pphase_t;

  // Predictor of decoded events plus store of events still to arrive.
  class event_scoreboard;
    pphase_t     phase[TRACK_COUNT];
    logic [7:0]  rstat[TRACK_COUNT];
    logic [6:0]  d1[TRACK_COUNT];
    logic [27:0] vlq[TRACK_COUNT];
    logic [7:0]  mtype[TRACK_COUNT];
    logic [27:0] remain[TRACK_COUNT];
    logic [31:0] tempo[TRACK_COUNT];
    logic [6:0]  chvol[16];
    out_item_t   pending[$];
    int          mismatches;
    int          events_seen;
    int          kinds_seen[16];

    function void clear_track(int t);
      phase[t] = P_DELTA;
      rstat[t] = '0;
      d1[t] = '0;
      vlq[t] = '0;
      mtype[t] = '0;
      remain[t] = '0;
      tempo[t] = '0;
    endfunction

    function void reset_all();
      for (int t = 0; t < TRACK_COUNT; t++) clear_track(t);
      for (int c = 0; c < 16; c++) chvol[c] = VOL_RESET;
      pending.delete();
    endfunction

    function void push(int t, logic [3:0] k, logic [3:0] ch, logic [6:0] key,
                       logic [6:0] vel, logic [31:0] val);
      out_item_t e;
      e.out_track = 4'(t);
      e.event_kind = k;
      e.channel = ch;
      e.key_or_number = key;
      e.velocity = vel;
      e.value = val;
      pending.push_back(e);
    endfunction

    function logic [31:0] scaled(logic [3:0] ch, logic [6:0] d);
      return (32'(chvol[ch]) * 32'(d)) / 32'd127;
    endfunction

    function void first_byte(int t, logic [6:0] d);
      logic [3:0] ch;
      ch = rstat[t][3:0];
      d1[t] = d;
      if (rstat[t][7:4] == ST_PROG) begin
        phase[t] = P_DELTA;
        push(t, EV_PROG, ch, d, 0, 0);
      end else if (rstat[t][7:4] == ST_PRESS) begin
        phase[t] = P_DELTA;
        push(t, EV_PRESS, ch, 0, d, scaled(ch, d));
      end else begin
        phase[t] = P_DATA2;
      end
    endfunction

    function void second_byte(int t, logic [6:0] d);
      logic [3:0] ch;
      ch = rstat[t][3:0];
      phase[t] = P_DELTA;
      case (rstat[t][7:4])
        ST_NOTE_OFF: push(t, EV_OFF, ch, d1[t], d, 0);
        ST_NOTE_ON: push(t, (d == 0) ? EV_OFF : EV_ON, ch, d1[t], d, 0);
        ST_CTRL: begin
          case (d1[t])
            CC_VOLUME: begin
              chvol[ch] = d;
              push(t, EV_VOL, ch, 0, d, 32'(d));
            end
            CC_PAN: push(t, EV_PAN, ch, 0, d, 0);
            CC_EXPR: push(t, EV_EXPR, ch, 0, d, scaled(ch, d));
            CC_SND_OFF: push(t, EV_SND_OFF, ch, 0, d, 0);
            CC_RST_CTL: push(t, EV_RST_CTL, ch, 0, d, 0);
            CC_NOTES_OFF: push(t, EV_NOTES_OFF, ch, 0, d, 0);
            default: ;
          endcase
        end
        ST_BEND: push(t, EV_BEND, ch, 0, 0, {18'd0, d, d1[t]});
        default: ;
      endcase
    endfunction

    // Note an accepted byte and queue any event it completes.
    function void note_input(in_item_t it);
      int          t;
      logic [7:0]  b;
      logic [6:0]  d;
      logic [27:0] acc;
      t = it.track;
      b = it.data_byte;
      d = b[6:0];
      if (t >= TRACK_COUNT) return;
      if (it.track_start) clear_track(t);
      acc = {vlq[t][20:0], d};
      case (phase[t])
        P_DELTA: begin
          if (b[7]) vlq[t] = acc;
          else begin
            vlq[t] = 0;
            phase[t] = P_STATUS;
            push(t, EV_DELTA, 0, 0, 0, 32'(acc));
          end
        end
        P_STATUS: begin
          if (!b[7]) begin
            if (rstat[t][7]) first_byte(t, d);
          end else begin
            vlq[t] = 0;
            if (b == META_STATUS) begin
              rstat[t] = 0;
              phase[t] = P_MTYPE;
            end else if (b >= SYS_FIRST) begin
              rstat[t] = 0;
              phase[t] = P_SXLEN;
            end else begin
              rstat[t] = b;
              phase[t] = P_DATA1;
            end
          end
        end
        P_DATA1: first_byte(t, d);
        P_DATA2: second_byte(t, d);
        P_MTYPE: begin
          mtype[t] = b;
          vlq[t] = 0;
          phase[t] = P_MLEN;
        end
        P_MLEN: begin
          if (b[7]) vlq[t] = acc;
          else begin
            vlq[t] = 0;
            tempo[t] = 0;
            remain[t] = acc;
            if (mtype[t] == META_END) begin
              phase[t] = P_ENDED;
              push(t, EV_END, 0, 0, 0, 0);
            end else if (acc == 0) begin
              phase[t] = P_DELTA;
              if (mtype[t] == META_SET_TEMPO) push(t, EV_TEMPO, 0, 0, 0, 0);
            end else phase[t] = P_MDATA;
          end
        end
        P_MDATA: begin
          tempo[t] = {tempo[t][23:0], b};
          remain[t] = remain[t] - 1;
          if (remain[t] == 0) begin
            phase[t] = P_DELTA;
            if (mtype[t] == META_SET_TEMPO) push(t, EV_TEMPO, 0, 0, 0, tempo[t]);
          end
        end
        P_SXLEN: begin
          if (b[7]) vlq[t] = acc;
          else begin
            vlq[t] = 0;
            remain[t] = acc;
            phase[t] = (acc == 0) ? P_DELTA : P_SXDATA;
          end
        end
        P_SXDATA: begin
          remain[t] = remain[t] - 1;
          if (remain[t] == 0) phase[t] = P_DELTA;
        end
        default: ;
      endcase
    endfunction

    function void report(string what, out_item_t exp_e, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %p, got %p", what, exp_e, got);
    endfunction

    // Compare one accepted event with the oldest one pending.
    function void check_event(out_item_t got);
      out_item_t e;
      events_seen++;
      kinds_seen[got.event_kind]++;
      if (pending.size() == 0) begin
        report("unexpected event", '0, got);
        return;
      end
      e = pending.pop_front();
      if (got.out_track !== e.out_track) report("out_track", e, got);
      else if (got.event_kind !== e.event_kind) report("event_kind", e, got);
      else if (got.channel !== e.channel) report("channel", e, got);
      else if (got.key_or_number !== e.key_or_number) report("key_or_number", e, got);
      else if (got.velocity !== e.velocity) report("velocity", e, got);
      else if (got.value !== e.value) report("value", e, got);
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_item;

  event_scoreboard sb = new();
  int bytes_sent = 0;
  bit stim_done = 0;

  always #4 clk = ~clk;

  midi_track_event_parser_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Noting happens at the edge of acceptance so the predictor sees bytes in order.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_item);
    if (!rst && out_valid && out_ready) sb.check_event(out_item);
  end

  // Receiver: random stalls, with quiet stretches of none.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
      out_ready <= 0;
      n = gap_len();
      repeat (n) @(posedge clk);
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // Send one byte; holds valid and payload until taken.
  task automatic send_byte(int t, int b, bit start);
    in_item_t it;
    int n;
    it.track = 4'(t);
    it.data_byte = 8'(b);
    it.track_start = start;
    in_item <= it;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_vlq(int t, int v);
    int grp[$];
    grp.push_front(v & 8'h7F);
    v = v >> 7;
    while (v != 0) begin
      grp.push_front(8'h80 | (v & 8'h7F));
      v = v >> 7;
    end
    foreach (grp[i]) send_byte(t, grp[i], 0);
  endtask

  // Event with random content after a random delta; some are malformed or noise bytes.
  task automatic send_random_event(int t);
    int r, ch, len;
    send_vlq(t, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300));
    r = $urandom_range(0, 13);
    ch = $urandom_range(0, 15);
    case (r)
      0, 1: begin
        send_byte(t, 8'h90 | ch, 0);
        send_byte(t, $urandom_range(0, 255), 0);
        send_byte(t, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255), 0);
      end
      2: begin
        send_byte(t, 8'h80 | ch, 0);
        send_byte(t, $urandom_range(0, 127), 0);
        send_byte(t, $urandom_range(0, 127), 0);
      end
      3, 4: begin
        send_byte(t, 8'hB0 | ch, 0);
        case ($urandom_range(0, 7))
          0, 1: send_byte(t, CC_VOLUME, 0);
          2: send_byte(t, CC_PAN, 0);
          3, 4: send_byte(t, CC_EXPR, 0);
          5: send_byte(t, CC_SND_OFF, 0);
          6: send_byte(t, ($urandom_range(0, 1)) ? CC_RST_CTL : CC_NOTES_OFF, 0);
          default: send_byte(t, $urandom_range(0, 127), 0);
        endcase
        send_byte(t, $urandom_range(0, 255), 0);
      end
      5: begin
        send_byte(t, 8'hC0 | ch, 0);
        send_byte(t, $urandom_range(0, 127), 0);
      end
      6: begin
        send_byte(t, 8'hD0 | ch, 0);
        send_byte(t, $urandom_range(0, 127), 0);
      end
      7: begin
        send_byte(t, 8'hE0 | ch, 0);
        send_byte(t, $urandom_range(0, 127), 0);
        send_byte(t, $urandom_range(0, 127), 0);
      end
      8: begin
        // running status data byte, possibly with none held
        send_byte(t, $urandom_range(0, 127), 0);
        if ($urandom_range(0, 1)) send_byte(t, $urandom_range(0, 127), 0);
      end
      9, 10: begin
        send_byte(t, META_STATUS, 0);
        send_byte(t, META_SET_TEMPO, 0);
        len = $urandom_range(0, 6);
        send_vlq(t, len);
        repeat (len) send_byte(t, $urandom_range(0, 255), 0);
      end
      11: begin
        send_byte(t, META_STATUS, 0);
        send_byte(t, $urandom_range(0, 127), 0);
        len = $urandom_range(0, 4);
        send_vlq(t, len);
        repeat (len) send_byte(t, $urandom_range(0, 255), 0);
      end
      12: begin
        send_byte(t, $urandom_range(SYS_FIRST, 8'hFE), 0);
        len = $urandom_range(0, 5);
        send_vlq(t, len);
        repeat (len) send_byte(t, $urandom_range(0, 255), 0);
      end
      default: begin
        // noise byte
        send_byte(t, $urandom_range(0, 255), $urandom_range(0, 9) == 0);
      end
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus: directed corner cases, then interleaved random tracks.
  initial begin
    int t;
    sb.reset_all();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Long delta wrapping past 28 bits, running status, bend extremes.
    send_byte(0, 8'hFF, 1);
    send_byte(0, 8'hFF, 0);
    send_byte(0, 8'hFF, 0);
    send_byte(0, 8'hFF, 0);
    send_byte(0, 8'h7F, 0);
    send_byte(0, 8'hE0, 0);
    send_byte(0, 8'hFF, 0);
    send_byte(0, 8'h7F, 0);
    send_byte(0, 8'h00, 0);
    send_byte(0, 8'h00, 0);
    send_byte(0, 8'h00, 0);
    // Volume to zero then pressure on channel 15.
    send_byte(15, 8'h00, 1);
    send_byte(15, 8'hBF, 0);
    send_byte(15, CC_VOLUME, 0);
    send_byte(15, 8'h00, 0);
    send_byte(15, 8'h00, 0);
    send_byte(15, 8'hDF, 0);
    send_byte(15, 8'h7F, 0);
    // End of track, then ignored bytes and a restart.
    send_byte(3, 8'h00, 1);
    send_byte(3, META_STATUS, 0);
    send_byte(3, META_END, 0);
    send_byte(3, 8'h00, 0);
    send_byte(3, 8'h90, 0);
    send_byte(3, 8'h05, 1);
    wait_drained();

    for (int i = 0; i < 90; i++) begin
      t = $urandom_range(0, 15);
      if (i == 45) wait_drained();
      if ($urandom_range(0, 19) == 0) begin
        send_byte(t, 8'h00, 1);
        send_byte(t, META_STATUS, 0);
        send_byte(t, META_END, 0);
        send_byte(t, $urandom_range(0, 255), 0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_byte(t, $urandom_range(0, 255), 1);
      end else begin
        send_random_event(t);
      end
      if (bytes_sent > 700) break;
    end
    while (bytes_sent < 700) send_random_event($urandom_range(0, 15));

    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d bytes, %0d events checked; notes %0d, controllers %0d,",
             bytes_sent, sb.events_seen, sb.kinds_seen[EV_ON] + sb.kinds_seen[EV_OFF],
             sb.kinds_seen[EV_VOL] + sb.kinds_seen[EV_EXPR] + sb.kinds_seen[EV_PAN]);
    $display("tempo %0d, bends %0d, end of track %0d, mismatches %0d.",
             sb.kinds_seen[EV_TEMPO], sb.kinds_seen[EV_BEND], sb.kinds_seen[EV_END],
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mtep_pkg.sv
sv/mtep_decode.sv
sv/midi_track_event_parser_top.sv
test/midi_track_event_parser_top_test.sv
